[sv/lcpfe_pkg.sv]
// Shared types, codes and constants of the LED chain PWM frame encoder.
`timescale 1ns / 1ps

package lcpfe_pkg;

  // Default size of the pixel store.
  localparam int PIXEL_COUNT_DEF = 64;

  // Buffer geometry: one pixel fills one half of the double buffer.
  localparam int HALF_SLOTS = 24;
  localparam int BIT_IDX_W  = 5;
  localparam int SLOT_W     = 6;

  // Action codes of an input word.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_HALF  = 2'd2;
  localparam logic [1:0] ACT_FULL  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_ONE_DUTY     = 2'd0;
  localparam logic [1:0] REG_ZERO_DUTY    = 2'd1;
  localparam logic [1:0] REG_RESET_EVENTS = 2'd2;

  // Configuration reset values.
  localparam logic [7:0] ONE_DUTY_RST     = 8'd60;
  localparam logic [7:0] ZERO_DUTY_RST    = 8'd20;
  localparam logic [7:0] RESET_EVENTS_RST = 8'd4;

  // Brightness is a percentage; anything above this is not stored.
  localparam logic [6:0] BRI_MAX = 7'd100;

  // Number of reset-phase events that put zeros into the buffer.
  localparam logic [7:0] ZERO_EVENTS = 8'd2;
  localparam logic [7:0] COUNT_MAX   = 8'd255;

  // Division by 100 as a reciprocal multiply, exact for products below 43690.
  localparam int          PROD_W    = 15;
  localparam int          QUO_W     = 28;
  localparam logic [12:0] DIV_MUL   = 13'd5243;
  localparam int          DIV_SHIFT = 19;

  // Channel selects for the scaling unit.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] brightness;
  } in_word_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [5:0] slot;
    logic       last;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 clr;
    logic                 px_we;
    logic                 bri_we;
    logic                 rd_en;
    logic                 mul_go;
    logic                 div_go;
    logic [1:0]           chan;
    logic                 emit;
    logic                 zero;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic                 base_hi;
    logic                 last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [7:0] reset_events;
  } stat_t;

endpackage

[sv/lcpfe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lcpfe_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[sv/lcpfe_ctrl.sv]
// Controller of the LED chain PWM frame encoder: sequencing state machine.
`timescale 1ns / 1ps

module lcpfe_ctrl #(
  parameter  int PIXEL_COUNT = 64,
  localparam int AW          = $clog2(PIXEL_COUNT),
  localparam int NPW         = $clog2(PIXEL_COUNT + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lcpfe_pkg::in_word_t in_word,
  input  lcpfe_pkg::stat_t   stat,
  output lcpfe_pkg::cmd_t    cmd,
  output logic [AW-1:0]      addr
);

  import lcpfe_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_MUL1,
    S_MUL2,
    S_EMIT,
    S_ZERO
  } state_t;

  state_t               state_r;
  logic [AW-1:0]        clr_addr_r;
  logic [AW-1:0]        cur_pix_r;
  logic [NPW-1:0]       next_pix_r;
  logic                 in_reset_r;
  logic [7:0]           rcnt_r;
  logic                 last_full_r;
  logic                 second_r;
  logic                 base_hi_r;
  logic [1:0]           chan_r;
  logic [BIT_IDX_W-1:0] bit_r;

  logic                 accept;
  logic                 ev_full;
  logic [NPW-1:0]       np_inc;
  logic [7:0]           rcnt_inc;
  logic                 idx_ok;
  logic                 bit_end;

  assign accept   = start && (state_r == S_IDLE);
  assign ev_full  = (in_word.action == ACT_FULL);
  assign np_inc   = next_pix_r + 1'b1;
  assign rcnt_inc = (rcnt_r < COUNT_MAX) ? rcnt_r + 8'd1 : rcnt_r;
  assign idx_ok   = (int'(in_word.pixel_index) < PIXEL_COUNT);
  assign bit_end  = (bit_r == BIT_IDX_W'(HALF_SLOTS - 1));
  assign busy     = (state_r != S_IDLE);

  // State and sequence registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      cur_pix_r   <= '0;
      next_pix_r  <= '0;
      in_reset_r  <= 1'b0;
      rcnt_r      <= '0;
      last_full_r <= 1'b1;
      second_r    <= 1'b0;
      base_hi_r   <= 1'b0;
      chan_r      <= '0;
      bit_r       <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AW'(PIXEL_COUNT - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          chan_r <= CH_RED;
          bit_r  <= '0;
          if (accept) begin
            unique case (in_word.action)
              ACT_WRITE: begin
                state_r <= S_IDLE;
              end
              ACT_START: begin
                next_pix_r  <= NPW'(2);
                in_reset_r  <= 1'b0;
                rcnt_r      <= '0;
                last_full_r <= 1'b1;
                cur_pix_r   <= '0;
                second_r    <= 1'b1;
                base_hi_r   <= 1'b0;
                state_r     <= S_READ;
              end
              default: begin
                // Half-done or full-done event; a repeat of the last kind is dropped.
                if (ev_full != last_full_r) begin
                  last_full_r <= ev_full;
                  base_hi_r   <= ev_full;
                  second_r    <= 1'b0;
                  if (!in_reset_r) begin
                    cur_pix_r  <= AW'(next_pix_r);
                    next_pix_r <= np_inc;
                    if (np_inc >= NPW'(PIXEL_COUNT)) begin
                      in_reset_r <= 1'b1;
                      rcnt_r     <= '0;
                    end
                    state_r <= S_READ;
                  end else begin
                    if (rcnt_r < ZERO_EVENTS) begin
                      state_r <= S_ZERO;
                    end
                    rcnt_r <= rcnt_inc;
                    if (rcnt_inc >= stat.reset_events) begin
                      next_pix_r <= '0;
                      in_reset_r <= 1'b0;
                    end
                  end
                end
              end
            endcase
          end
        end
        S_READ: begin
          chan_r  <= CH_RED;
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          if (chan_r == CH_BLUE) begin
            bit_r   <= '0;
            state_r <= S_EMIT;
          end else begin
            chan_r  <= chan_r + 2'd1;
            state_r <= S_MUL1;
          end
        end
        S_EMIT: begin
          bit_r <= bit_r + 1'b1;
          if (bit_end) begin
            if (second_r) begin
              // Start item: the second pixel goes into the upper half.
              second_r  <= 1'b0;
              cur_pix_r <= AW'(1);
              base_hi_r <= 1'b1;
              state_r   <= S_READ;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_ZERO: begin
          bit_r <= bit_r + 1'b1;
          if (bit_end) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd         = '0;
    cmd.clr     = (state_r == S_CLEAR);
    cmd.px_we   = accept && (in_word.action == ACT_WRITE) && idx_ok;
    cmd.bri_we  = cmd.px_we && (in_word.brightness <= BRI_MAX);
    cmd.rd_en   = (state_r == S_READ);
    cmd.mul_go  = (state_r == S_MUL1);
    cmd.div_go  = (state_r == S_MUL2);
    cmd.chan    = chan_r;
    cmd.emit    = (state_r == S_EMIT);
    cmd.zero    = (state_r == S_ZERO);
    cmd.bit_idx = bit_r;
    cmd.base_hi = base_hi_r;
    cmd.last    = bit_end && (((state_r == S_EMIT) && !second_r) || (state_r == S_ZERO));
  end

  assign addr = (state_r == S_CLEAR) ? clr_addr_r : cur_pix_r;

  // Checks on the sequencing.
  a_emit_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.emit && cmd.zero))
    else $error("pixel and zero emission at once");

  a_pix_range: assert property (@(posedge clk) disable iff (!rst_n)
    !in_reset_r |-> (next_pix_r < NPW'(PIXEL_COUNT)))
    else $error("next pixel out of range in pixel phase");

  a_start_read: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_word.action == ACT_START)) |=> (state_r == S_READ))
    else $error("start word did not begin a pixel read");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.px_we |-> (state_r == S_IDLE))
    else $error("pixel write outside idle");

endmodule

[sv/lcpfe_dp.sv]
// Datapath of the LED chain PWM frame encoder: store, scaling and result register.
`timescale 1ns / 1ps

module lcpfe_dp #(
  parameter  int PIXEL_COUNT = 64,
  localparam int AW          = $clog2(PIXEL_COUNT)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcpfe_pkg::in_word_t  in_word,
  input  lcpfe_pkg::cmd_t      cmd,
  input  logic [AW-1:0]        addr,
  output lcpfe_pkg::stat_t     stat,
  input  logic                 cfg_valid,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 out_valid,
  output lcpfe_pkg::out_word_t out_word
);

  import lcpfe_pkg::*;

  logic [7:0]        one_duty_r;
  logic [7:0]        zero_duty_r;
  logic [7:0]        reset_events_r;

  logic              col_we;
  logic              bri_we;
  logic [AW-1:0]     wr_addr;
  logic [23:0]       col_wdata;
  logic [6:0]        bri_wdata;
  logic [23:0]       col_rdata;
  logic [6:0]        bri_rdata;

  logic [7:0]        chan_val;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_r;
  logic [QUO_W-1:0]  quo;
  logic [7:0]        scaled_r [3];
  logic [23:0]       pix_bits;
  logic [4:0]        bit_sel;
  logic              cur_bit;

  logic              out_valid_r;
  out_word_t         out_word_r;

  // Configuration registers; the write channel is always ready.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_duty_r     <= ONE_DUTY_RST;
      zero_duty_r    <= ZERO_DUTY_RST;
      reset_events_r <= RESET_EVENTS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ONE_DUTY:     one_duty_r     <= cfg_data;
        REG_ZERO_DUTY:    zero_duty_r    <= cfg_data;
        REG_RESET_EVENTS: reset_events_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign stat.reset_events = reset_events_r;

  // Pixel store: colour and brightness apart, so brightness can be kept.
  assign col_we    = cmd.clr || cmd.px_we;
  assign bri_we    = cmd.clr || cmd.bri_we;
  assign wr_addr   = cmd.clr ? addr : AW'(in_word.pixel_index);
  assign col_wdata = cmd.clr ? 24'd0 : {in_word.red, in_word.green, in_word.blue};
  assign bri_wdata = cmd.clr ? 7'd0 : in_word.brightness;

  lcpfe_ram #(.WIDTH(24), .DEPTH(PIXEL_COUNT)) u_col_ram (
    .clk     (clk),
    .wr_en   (col_we),
    .wr_addr (wr_addr),
    .wr_data (col_wdata),
    .rd_en   (cmd.rd_en),
    .rd_addr (addr),
    .rd_data (col_rdata)
  );

  lcpfe_ram #(.WIDTH(7), .DEPTH(PIXEL_COUNT)) u_bri_ram (
    .clk     (clk),
    .wr_en   (bri_we),
    .wr_addr (wr_addr),
    .wr_data (bri_wdata),
    .rd_en   (cmd.rd_en),
    .rd_addr (addr),
    .rd_data (bri_rdata)
  );

  // Channel select for the shared scaling unit.
  always_comb begin
    unique case (cmd.chan)
      CH_RED:   chan_val = col_rdata[23:16];
      CH_GREEN: chan_val = col_rdata[15:8];
      CH_BLUE:  chan_val = col_rdata[7:0];
      default:  chan_val = 8'd0;
    endcase
  end

  // First step: channel times brightness percent.
  assign prod = {7'd0, chan_val} * {8'd0, bri_rdata};

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_r <= prod;
    end
  end

  // Second step: divide by 100 through the reciprocal.
  assign quo = {13'd0, prod_r} * {15'd0, DIV_MUL};

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      scaled_r[cmd.chan] <= quo[DIV_SHIFT +: 8];
    end
  end

  // Bit to send: red, green, blue, each most significant bit first.
  assign pix_bits = {scaled_r[0], scaled_r[1], scaled_r[2]};
  assign bit_sel  = 5'(HALF_SLOTS - 1) - cmd.bit_idx;
  assign cur_bit  = pix_bits[bit_sel];

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit || cmd.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit || cmd.zero) begin
      out_word_r.duty <= cmd.zero ? 8'd0 : (cur_bit ? one_duty_r : zero_duty_r);
      out_word_r.slot <= cmd.base_hi ? SLOT_W'(cmd.bit_idx) + SLOT_W'(HALF_SLOTS)
                                     : SLOT_W'(cmd.bit_idx);
      out_word_r.last <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Checks on the result register.
  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last) |->
      ((out_word.slot == 6'd23) || (out_word.slot == 6'd47)))
    else $error("last word outside the final slot of a half");

  a_zero_duty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.zero |=> (out_valid && (out_word.duty == 8'd0)))
    else $error("reset-phase word with nonzero duty");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.slot < 6'd48))
    else $error("slot beyond the double buffer");

endmodule

[sv/led_chain_pwm_frame_encoder.sv]
// Top level of the LED chain PWM frame encoder.
`timescale 1ns / 1ps

// Turns a store of pixel colours into PWM compare words for a 48-slot double buffer.
// Input channel: a word is taken at a rising edge with start high and busy low.
// Pixel-write words and repeated or counting-only events leave busy low.
// A buffer-half event on pixel data runs one store read, channel scaling through
// one shared two-step scaling unit (percent product, then reciprocal divide by 100)
// for red, green and blue in turn, and the emission of 24 words. A zero-filling
// reset-phase event emits 24 zero-duty words.
// A start word produces two pixels, 48 words.
// Results leave one per cycle from a register, each valid for exactly one cycle
// while out_valid is high; on pixel data the first follows the store read and
// the scaling, on a zero-filling event the zero state. The receiver cannot stall,
// so nothing is held back. Outputs pause between the two pixels of a start word
// while the second pixel is read and scaled.
// After reset the pixel store is cleared, one entry a cycle, with busy high;
// configuration writes are taken at any time and the configuration port is
// always ready. Configuration returns to its defaults.
module led_chain_pwm_frame_encoder #(
  parameter int PIXEL_COUNT = lcpfe_pkg::PIXEL_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  lcpfe_pkg::in_word_t  in_word,
  output logic                 out_valid,
  output lcpfe_pkg::out_word_t out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data
);

  import lcpfe_pkg::*;

  localparam int AW = $clog2(PIXEL_COUNT);

  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] addr;

  assign cfg_ready = 1'b1;

  // Sequencing.
  lcpfe_ctrl #(.PIXEL_COUNT(PIXEL_COUNT)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_word (in_word),
    .stat    (stat),
    .cmd     (cmd),
    .addr    (addr)
  );

  // Store, scaling and result register.
  lcpfe_dp #(.PIXEL_COUNT(PIXEL_COUNT)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .addr      (addr),
    .stat      (stat),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
